[rtl/core/tdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

  // table size and the widths that follow from it
  localparam int PRIME_COUNT = 8192;
  localparam int ADDR_W      = $clog2(PRIME_COUNT);
  localparam int CNT_W       = $clog2(PRIME_COUNT + 1);

  // candidate magnitude (sign bit dropped) and table entry widths
  localparam int N_W  = 31;
  localparam int P_W  = 16;
  localparam int SQ_W = 2 * P_W;

  // last value tried when the table is built
  localparam logic [P_W-1:0] LAST_CAND  = '1;
  localparam logic [N_W-1:0] FIRST_CAND = N_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_CMP,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic           go;
    logic           narrow;
    logic [N_W-1:0] dividend;
    logic [P_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/tdp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tdp_rem.sv]
`timescale 1ns / 1ps
`default_nettype none

// restoring remainder, one dividend bit per cycle
module tdp_rem (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tdp_pkg::div_req_t req_i,
  output tdp_pkg::div_rsp_t      rsp_o
);

  localparam int SC_W = $clog2(tdp_pkg::N_W);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [SC_W-1:0]         cnt_q, cnt_d;
  logic [tdp_pkg::N_W-1:0] dvd_q, dvd_d;
  logic [tdp_pkg::P_W-1:0] rem_q, rem_d;
  logic [tdp_pkg::P_W-1:0] dsr_q, dsr_d;
  logic [tdp_pkg::P_W:0]   trial;
  logic [tdp_pkg::P_W:0]   diff;

  always_comb begin
    trial  = {rem_q, dvd_q[tdp_pkg::N_W-1]};
    diff   = trial - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (busy_q) begin
      rem_d = (trial >= {1'b0, dsr_q}) ? diff[tdp_pkg::P_W-1:0] : trial[tdp_pkg::P_W-1:0];
      dvd_d = {dvd_q[tdp_pkg::N_W-2:0], 1'b0};
      cnt_d = cnt_q - SC_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.go) begin
      busy_d = 1'b1;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      // small dividends skip the leading zero half
      if (req_i.narrow) begin
        dvd_d = {req_i.dividend[tdp_pkg::P_W-1:0], (tdp_pkg::N_W - tdp_pkg::P_W)'(0)};
        cnt_d = SC_W'(tdp_pkg::P_W - 1);
      end else begin
        dvd_d = req_i.dividend;
        cnt_d = SC_W'(tdp_pkg::N_W - 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule

`default_nettype wire

[rtl/core/trial_division_prime_test.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                      beat
// command   in         start, busy, candidate_i   start high while busy low
// result    out        done_o, prime_flag_o       done_o high for one cycle
//
// answer: candidates of one or less answer from idle with no table walk; otherwise the time
//   grows with each table prime walked, set by the bit-serial remainder unit, whose divisions
//   are shorter when the candidate is below 65536
// reset: the prime table is built in place by the same walk over 2..65535, busy until the
//   table is built, and no command is taken before then
// stalls: the receiver cannot stall; a new command may be taken in the cycle a result shows
module trial_division_prime_test (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] candidate_i,
  output logic             done_o,
  output logic             prime_flag_o
);

  tdp_pkg::state_e state_q, state_d;

  logic                      fill_q, fill_d;
  logic [tdp_pkg::CNT_W-1:0] count_q, count_d;
  logic [tdp_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [tdp_pkg::N_W-1:0]   n_q, n_d;
  logic                      done_q, done_d;
  logic                      flag_q, flag_d;
  logic [tdp_pkg::P_W-1:0]   p_q, p_d;
  logic [tdp_pkg::SQ_W-1:0]  sq_q, sq_d;

  logic                      ram_we;
  logic                      ram_re;
  logic [tdp_pkg::P_W-1:0]   ram_rdata;
  logic                      finish;
  logic                      verdict;

  tdp_pkg::div_req_t div_req;
  tdp_pkg::div_rsp_t div_rsp;

  // reads always sit below count_q and the only write goes to count_q, so no forwarding
  tdp_ram #(
    .WIDTH(tdp_pkg::P_W),
    .DEPTH(tdp_pkg::PRIME_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[tdp_pkg::ADDR_W-1:0]),
    .wdata_i(n_q[tdp_pkg::P_W-1:0]),
    .re_i   (ram_re),
    .raddr_i(idx_q[tdp_pkg::ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  tdp_rem u_rem (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    count_d = count_q;
    idx_d   = idx_q;
    n_d     = n_q;
    done_d  = 1'b0;
    flag_d  = flag_q;
    p_d     = p_q;
    sq_d    = sq_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    finish  = 1'b0;
    verdict = 1'b0;
    busy    = (state_q != tdp_pkg::ST_IDLE);

    div_req.go       = 1'b0;
    div_req.narrow   = (n_q[tdp_pkg::N_W-1:tdp_pkg::P_W] == '0);
    div_req.dividend = n_q;
    div_req.divisor  = p_q;

    case (state_q)
      tdp_pkg::ST_IDLE: begin
        if (start) begin
          if (candidate_i[31] || (candidate_i[30:1] == '0)) begin
            done_d = 1'b1;
            flag_d = 1'b0;
          end else begin
            n_d     = candidate_i[tdp_pkg::N_W-1:0];
            idx_d   = '0;
            state_d = tdp_pkg::ST_START;
          end
        end
      end
      tdp_pkg::ST_START: begin
        if (idx_q == count_q) begin
          // walked off the end of the table
          finish  = 1'b1;
          verdict = 1'b1;
        end else begin
          ram_re  = 1'b1;
          state_d = tdp_pkg::ST_READ;
        end
      end
      tdp_pkg::ST_READ: begin
        p_d     = ram_rdata;
        sq_d    = {{tdp_pkg::P_W{1'b0}}, ram_rdata} * {{tdp_pkg::P_W{1'b0}}, ram_rdata};
        state_d = tdp_pkg::ST_CMP;
      end
      tdp_pkg::ST_CMP: begin
        if (sq_q > {1'b0, n_q}) begin
          finish  = 1'b1;
          verdict = 1'b1;
        end else begin
          div_req.go = 1'b1;
          state_d    = tdp_pkg::ST_DIV;
        end
      end
      tdp_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.zero) begin
            finish  = 1'b1;
            verdict = 1'b0;
          end else begin
            idx_d   = idx_q + tdp_pkg::CNT_W'(1);
            state_d = tdp_pkg::ST_START;
          end
        end
      end
      default: begin
        state_d = tdp_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      if (fill_q) begin
        // table build: append primes, try the next value, stop at the last or when full
        if (verdict) begin
          ram_we  = 1'b1;
          count_d = count_q + tdp_pkg::CNT_W'(1);
        end
        if ((n_q[tdp_pkg::P_W-1:0] == tdp_pkg::LAST_CAND) ||
            (verdict &&
             (count_q + tdp_pkg::CNT_W'(1) == tdp_pkg::CNT_W'(tdp_pkg::PRIME_COUNT)))) begin
          fill_d  = 1'b0;
          state_d = tdp_pkg::ST_IDLE;
        end else begin
          n_d     = n_q + tdp_pkg::N_W'(1);
          idx_d   = '0;
          state_d = tdp_pkg::ST_START;
        end
      end else begin
        done_d  = 1'b1;
        flag_d  = verdict;
        state_d = tdp_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdp_pkg::ST_START;
      fill_q  <= 1'b1;
      count_q <= '0;
      idx_q   <= '0;
      n_q     <= tdp_pkg::FIRST_CAND;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
    p_q    <= p_d;
    sq_q   <= sq_d;
  end

  assign done_o       = done_q;
  assign prime_flag_o = flag_q;

endmodule

`default_nettype wire
